[rtl/moment_sum_accumulator_assert.svh]
// Assertion macros shared by the moment sum accumulator RTL.
// Expects clock aclk and active-low reset aresetn in the including module.
`ifndef MOMENT_SUM_ACCUMULATOR_ASSERT_SVH
`define MOMENT_SUM_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define MSA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/msa_pkg.sv]
// Shared types and constants of the moment sum accumulator.
// Used by msa_err and moment_sum_accumulator; depends on nothing.
package msa_pkg;

    localparam int unsigned NUM_HISTS_DEF   = 16;
    localparam int unsigned MAX_MOMENTS_DEF = 8;

    localparam int unsigned SUM_W  = 48;  // Q32.16 power sum
    localparam int unsigned ERR_W  = 32;  // Q16.16 error
    localparam int unsigned VAL_W  = 16;  // Q0.16 magnitude
    localparam int unsigned PWR_W  = 17;  // Q1.16 power, holds 1.0
    localparam int unsigned ID_W   = 4;
    localparam int unsigned FUNC_W = 2;
    localparam int unsigned BIN_W  = 4;
    localparam int unsigned CFG_W  = 4;
    localparam int unsigned K_W    = 5;   // bin counter, covers a full row

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd5;
    localparam logic [PWR_W-1:0] ONE_Q16   = 17'h10000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FILL  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // Request from the sequencer to the error unit
    typedef struct packed {
        logic start;
        logic bin_zero;   // bin 0: sqrt of the count
        logic use_var;    // variance bin with nonzero count
    } err_req_t;

    // Answer of the error unit
    typedef struct packed {
        logic             done;
        logic [ERR_W-1:0] error;
    } err_rsp_t;

endpackage

[rtl/msa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module msa_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 144
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/msa_err.sv]
// Error unit: shared 24x24 multiplier, bit-serial divider and square root.
// Depends on msa_pkg.
module msa_err
    import msa_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  err_req_t         req,
    input  logic [SUM_W-1:0] s0,
    input  logic [SUM_W-1:0] sk,
    input  logic [SUM_W-1:0] s2k,
    output err_rsp_t         rsp
);

    typedef enum logic [2:0] {
        E_IDLE, E_MUL, E_DIVCHK, E_DIV, E_VAR, E_SQRT, E_DONE
    } estate_t;

    estate_t                state_reg;
    logic [5:0]             step_reg;
    logic [2*SUM_W-1:0]     prod_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [SUM_W-1:0]       quo_reg;
    logic [63:0]            x_reg;
    logic [ERR_W-1:0]       root_reg;
    logic [ERR_W+2:0]       srem_reg;
    logic [ERR_W-1:0]       err_reg;

    logic [23:0]            mul_a, mul_b;
    logic [47:0]            pp;
    logic [2*SUM_W-1:0]     prod_next;
    logic [SUM_W:0]         div_t;
    logic [ERR_W+2:0]       sq_t, sq_trial;

    // Select partial product operands
    always_comb begin
        mul_a = sk[23:0];
        mul_b = sk[23:0];
        case (step_reg[1:0])
            2'd0:    begin mul_a = sk[23:0];  mul_b = sk[23:0];  end
            2'd1:    begin mul_a = sk[47:24]; mul_b = sk[23:0];  end
            default: begin mul_a = sk[47:24]; mul_b = sk[47:24]; end
        endcase
    end

    assign pp = 48'(mul_a) * 48'(mul_b);

    // Accumulate the square of sk
    always_comb begin
        case (step_reg[1:0])
            2'd0:    prod_next = 96'(pp);
            2'd1:    prod_next = prod_reg + (96'(pp) << 25);
            default: prod_next = prod_reg + (96'(pp) << 48);
        endcase
    end

    assign div_t    = {rem_reg, prod_reg[SUM_W-1]};
    assign sq_t     = {srem_reg[ERR_W:0], x_reg[63:62]};
    assign sq_trial = {1'b0, root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                E_IDLE: begin
                    step_reg <= '0;
                    if (req.start) begin
                        if (req.bin_zero) begin
                            x_reg     <= {s0, 16'b0};
                            root_reg  <= '0;
                            srem_reg  <= '0;
                            state_reg <= E_SQRT;
                        end else if (req.use_var) begin
                            state_reg <= E_MUL;
                        end else begin
                            err_reg   <= '0;
                            state_reg <= E_DONE;
                        end
                    end
                end
                // Three partial products, one per cycle
                E_MUL: begin
                    prod_reg <= prod_next;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd2) begin
                        state_reg <= E_DIVCHK;
                    end
                end
                // Drop quotients of 2^48 and more: they exceed any s2k
                E_DIVCHK: begin
                    step_reg <= '0;
                    quo_reg  <= '0;
                    if (prod_reg[2*SUM_W-1:SUM_W] >= s0) begin
                        err_reg   <= '0;
                        state_reg <= E_DONE;
                    end else begin
                        rem_reg   <= prod_reg[2*SUM_W-1:SUM_W];
                        state_reg <= E_DIV;
                    end
                end
                // Restoring division, one quotient bit per cycle
                E_DIV: begin
                    if (div_t >= {1'b0, s0}) begin
                        rem_reg <= SUM_W'(div_t - {1'b0, s0});
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= div_t[SUM_W-1:0];
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    prod_reg <= {prod_reg[2*SUM_W-2:0], 1'b0};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(SUM_W - 1)) begin
                        state_reg <= E_VAR;
                    end
                end
                // Negative variance gives zero
                E_VAR: begin
                    step_reg <= '0;
                    root_reg <= '0;
                    srem_reg <= '0;
                    if (quo_reg > s2k) begin
                        err_reg   <= '0;
                        state_reg <= E_DONE;
                    end else begin
                        x_reg     <= {s2k - quo_reg, 16'b0};
                        state_reg <= E_SQRT;
                    end
                end
                // Digit-by-digit square root, one root bit per cycle
                E_SQRT: begin
                    if (sq_t >= sq_trial) begin
                        srem_reg <= sq_t - sq_trial;
                        root_reg <= {root_reg[ERR_W-2:0], 1'b1};
                    end else begin
                        srem_reg <= sq_t;
                        root_reg <= {root_reg[ERR_W-2:0], 1'b0};
                    end
                    x_reg    <= {x_reg[61:0], 2'b00};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(ERR_W - 1)) begin
                        state_reg <= E_DONE;
                    end
                end
                E_DONE: begin
                    state_reg <= E_IDLE;
                end
                default: begin
                    state_reg <= E_IDLE;
                end
            endcase
            if (state_reg == E_SQRT && step_reg == 6'(ERR_W - 1)) begin
                err_reg <= {root_reg[ERR_W-2:0], (sq_t >= sq_trial)};
            end
        end
    end

    assign rsp.done  = (state_reg == E_DONE);
    assign rsp.error = err_reg;

endmodule

[rtl/moment_sum_accumulator.sv]
// Moment sum accumulator: power sums of NUM_HISTS histograms in one RAM.
// One transaction in flight: a fill, a row clear or a readout. In a readout each bin starts
// the error unit: a square root for bin 0, a product, division and square root for variance
// bins (stopping early when the quotient overflows or the variance is negative), zero otherwise.
// After reset a clearing pass zeroes all NUM_HISTS*(MAX_MOMENTS+1) RAM words.
// Depends on msa_pkg, msa_ram, msa_err and moment_sum_accumulator_assert.svh.
`include "moment_sum_accumulator_assert.svh"

module moment_sum_accumulator
    import msa_pkg::*;
#(
    parameter int unsigned NUM_HISTS   = NUM_HISTS_DEF,
    parameter int unsigned MAX_MOMENTS = MAX_MOMENTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // [3:0] hist_id, [20:4] value, [23:21] zero
    input  logic [1:0]       s_tuser,   // [1:0] func
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [87:0]      m_tdata,   // [3:0] bin_index, [51:4] bin_sum,
                                        // [83:52] bin_error, [87:84] zero
    output logic             m_tlast,   // last
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data   // moments_in_use
);

    localparam int unsigned NBINS = MAX_MOMENTS + 1;
    localparam int unsigned DEPTH = NUM_HISTS * NBINS;
    localparam int unsigned AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FILL_RD, S_FILL_WR, S_CLR,
        S_R_S0, S_R_S0C, S_R_SK, S_R_SKC, S_R_S2K, S_R_S2KC,
        S_ERR_GO, S_ERR, S_EMIT
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      init_cnt_reg;
    logic [CFG_W-1:0]   cfg_reg;
    logic [CFG_W-1:0]   m_reg;
    logic [AW-1:0]      base_reg;
    logic [K_W-1:0]     k_reg;
    logic [PWR_W-1:0]   p_reg;
    logic [VAL_W-1:0]   v_reg;
    logic [SUM_W-1:0]   s0_reg, sk_reg, s2k_reg;
    logic [ERR_W-1:0]   err_reg;
    logic               m_tvalid_reg, m_tlast_reg;
    logic [BIN_W-1:0]   out_index_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic [ERR_W-1:0]   out_err_reg;

    logic [ID_W-1:0]    in_id;
    logic [PWR_W-1:0]   in_value;
    logic [CFG_W-1:0]   m_act;
    logic               id_ok;
    logic [PWR_W-1:0]   p_next;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   sum_sat;
    logic [K_W:0]       two_k;
    logic               k_last, use_var;
    logic               mem_we;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [SUM_W-1:0]   wr_data, rd_data;
    err_req_t           err_req;
    err_rsp_t           err_rsp;

    assign in_id    = s_tdata[3:0];
    assign in_value = s_tdata[20:4];
    assign id_ok    = (32'(in_id) < NUM_HISTS);

    // Clamp the moment count register into range
    always_comb begin
        if (cfg_reg == '0) begin
            m_act = CFG_W'(1);
        end else if (32'(cfg_reg) > MAX_MOMENTS) begin
            m_act = CFG_W'(MAX_MOMENTS);
        end else begin
            m_act = cfg_reg;
        end
    end

    // Fill arithmetic: saturating add and next power
    assign sum_ext = {1'b0, rd_data} + (SUM_W + 1)'(p_reg);
    assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    assign p_next  = PWR_W'((33'(p_reg) * 33'(v_reg)) >> 16);

    assign two_k   = {k_reg, 1'b0};
    assign k_last  = (k_reg == K_W'(m_reg));
    assign use_var = (k_reg != '0) && (two_k <= (K_W + 1)'(m_reg)) && (s0_reg != '0);

    // RAM port control
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = base_reg + AW'(k_reg);
        wr_data = '0;
        rd_addr = base_reg + AW'(k_reg);
        case (state_reg)
            S_INIT: begin
                mem_we  = 1'b1;
                wr_addr = init_cnt_reg;
            end
            S_FILL_WR: begin
                mem_we  = 1'b1;
                wr_data = sum_sat;
            end
            S_CLR:   mem_we  = 1'b1;
            S_R_S0:  rd_addr = base_reg;
            S_R_S2K: rd_addr = base_reg + AW'(two_k);
            default: ;
        endcase
    end

    msa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign err_req.start    = (state_reg == S_ERR_GO);
    assign err_req.bin_zero = (k_reg == '0);
    assign err_req.use_var  = use_var;

    msa_err u_err (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (err_req),
        .s0      (s0_reg),
        .sk      (sk_reg),
        .s2k     (s2k_reg),
        .rsp     (err_rsp)
    );

    // Sequencer: state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            cfg_reg      <= CFG_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            // Drop the output once taken, unless a new bin replaces it
            if (m_tvalid_reg && m_tready && state_reg != S_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    init_cnt_reg <= init_cnt_reg + AW'(1);
                    if (init_cnt_reg == AW'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    m_reg    <= m_act;
                    base_reg <= AW'(32'(in_id) * NBINS);
                    k_reg    <= '0;
                    p_reg    <= ONE_Q16;
                    v_reg    <= in_value[VAL_W-1:0];
                    if (s_tvalid && id_ok) begin
                        case (s_tuser)
                            FUNC_FILL:  if (!in_value[PWR_W-1]) state_reg <= S_FILL_RD;
                            FUNC_READ:  state_reg <= S_R_S0;
                            FUNC_CLEAR: state_reg <= S_CLR;
                            default:    ;
                        endcase
                    end
                end
                S_FILL_RD: state_reg <= S_FILL_WR;
                // Write back the sum and advance the power
                S_FILL_WR: begin
                    p_reg <= p_next;
                    k_reg <= k_reg + K_W'(1);
                    state_reg <= k_last ? S_IDLE : S_FILL_RD;
                end
                // Zero the whole row
                S_CLR: begin
                    k_reg <= k_reg + K_W'(1);
                    if (k_reg == K_W'(NBINS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_R_S0:  state_reg <= S_R_S0C;
                S_R_S0C: begin
                    s0_reg    <= rd_data;
                    state_reg <= S_R_SK;
                end
                S_R_SK:  state_reg <= S_R_SKC;
                S_R_SKC: begin
                    sk_reg    <= rd_data;
                    state_reg <= use_var ? S_R_S2K : S_ERR_GO;
                end
                S_R_S2K:  state_reg <= S_R_S2KC;
                S_R_S2KC: begin
                    s2k_reg   <= rd_data;
                    state_reg <= S_ERR_GO;
                end
                S_ERR_GO: state_reg <= S_ERR;
                S_ERR: begin
                    if (err_rsp.done) begin
                        err_reg   <= err_rsp.error;
                        state_reg <= S_EMIT;
                    end
                end
                // Load the output register once it is free
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        out_index_reg <= BIN_W'(k_reg);
                        out_sum_reg   <= sk_reg;
                        out_err_reg   <= err_reg;
                        m_tlast_reg   <= k_last;
                        k_reg         <= k_reg + K_W'(1);
                        state_reg     <= k_last ? S_IDLE : S_R_SK;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tdata   = {4'b0, out_err_reg, out_sum_reg, out_index_reg};

    `MSA_ASSERT(a_we_state, mem_we, state_reg == S_INIT || state_reg == S_FILL_WR || state_reg == S_CLR, "RAM write outside init, fill or clear")
    `MSA_ASSERT(a_done_wait, err_rsp.done, state_reg == S_ERR, "error result with no waiting bin")
    `MSA_ASSERT_NEXT(a_start_wait, err_req.start, state_reg == S_ERR, "error start not followed by wait")
    `MSA_ASSERT(a_init_block, state_reg == S_INIT, !s_tready && !m_tvalid_reg, "traffic during clearing pass")

endmodule
